[hw/rtl/ray_plane_intersection_macros.svh]
// assertion macros for the ray-plane intersection block
// no dependencies; included by files that carry concurrent assertions
`ifndef RAY_PLANE_INTERSECTION_MACROS_SVH
`define RAY_PLANE_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define RPI_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RPI_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RPI_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RPI_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/rpi_pkg.sv]
// widths, result codes and the divider item type of the ray-plane block
// no dependencies
`default_nettype none
package rpi_pkg;
  localparam int CoordW  = 32;
  localparam int FracW   = 16;
  localparam int TolW    = 17;
  localparam int LimW    = TolW + FracW;
  localparam int DiffW   = CoordW + 1;
  localparam int PnW     = CoordW + DiffW;
  localparam int NdW     = 2 * CoordW;
  localparam int NumW    = PnW + 2;
  localparam int DenW    = NdW + 2;
  localparam int NumMagW = PnW;
  localparam int DenMagW = NdW;
  localparam int LoW     = 33;
  localparam int HiW     = NumMagW - LoW;
  localparam int PlW     = LoW + CoordW;
  localparam int PhW     = HiW + CoordW;
  localparam int AW      = PhW + LoW;
  localparam int QuoW    = 34;
  localparam int RemW    = DenMagW + QuoW + 1;
  localparam int HitW    = QuoW + 2;
  localparam int InW     = 12 * CoordW;
  localparam int OutW    = 3 * CoordW;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_IN_PLANE = 2'd1,
    ST_NONE     = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0][CoordW-1:0] p;
    logic [RemW-1:0]        dvs;
    logic [2:0][RemW-1:0]   rem;
    logic [2:0][QuoW-1:0]   quo;
    logic [2:0]             neg;
    logic [2:0]             ovf;
    logic                   den_near;
    logic                   num_near;
  } div_item_t;
endpackage
`default_nettype wire

[hw/rtl/rpi_front.sv]
// front pipeline: plane offset, dot products, tolerance tests, dividend setup
// depends on rpi_pkg
`default_nettype none
module rpi_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [rpi_pkg::TolW-1:0]  tol_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [rpi_pkg::InW-1:0]   in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output rpi_pkg::div_item_t             out_item_o
);
  import rpi_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic r1, r2, r3, r4, r5, r6, r7;

  logic [2:0][CoordW-1:0] p1_q, d1_q, n1_q, p2_q, d2_q, p3_q, d3_q, p4_q, p5_q, p6_q;
  logic [2:0][DiffW-1:0]  dq1_q, dq1_d;
  logic [2:0][PnW-1:0]    pn2_q, pn2_d;
  logic [2:0][NdW-1:0]    nd2_q, nd2_d;
  logic [NumW-1:0]        num3_q, num3_d;
  logic [DenW-1:0]        den3_q, den3_d;
  logic [NumMagW-1:0]     nmag4_q, nmag4_d;
  logic [2:0][CoordW-1:0] dmag4_q, dmag4_d;
  logic [DenMagW-1:0]     dm4_q, dm4_d, dm5_q, dm6_q;
  logic [2:0]             neg4_q, neg4_d, neg5_q, neg6_q;
  logic [1:0]             fl4_q, fl4_d, fl5_q, fl6_q;
  logic [2:0][PlW-1:0]    pl5_q, pl5_d;
  logic [2:0][PhW-1:0]    ph5_q, ph5_d;
  logic [2:0][RemW-1:0]   a6_q, a6_d;
  div_item_t              it7_q, it7_d;

  logic [NumW-1:0] num_abs;
  logic [DenW-1:0] den_abs;
  logic [LimW-1:0] limit;
  logic [AW-1:0]   a_mag;

  assign r7 = !v7_q || out_ready_i;
  assign r6 = !v6_q || r7;
  assign r5 = !v5_q || r6;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o  = r1;
  assign out_valid_o = v7_q;
  assign out_item_o  = it7_q;
  assign limit = {tol_i, {FracW{1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dq1_d[i] = {in_data_i[i*CoordW + CoordW-1], in_data_i[i*CoordW +: CoordW]}
               - {in_data_i[(9+i)*CoordW + CoordW-1], in_data_i[(9+i)*CoordW +: CoordW]};
      pn2_d[i] = $signed(n1_q[i]) * $signed(dq1_q[i]);
      nd2_d[i] = $signed(n1_q[i]) * $signed(d1_q[i]);
    end
    num3_d = {{2{pn2_q[0][PnW-1]}}, pn2_q[0]} + {{2{pn2_q[1][PnW-1]}}, pn2_q[1]}
           + {{2{pn2_q[2][PnW-1]}}, pn2_q[2]};
    den3_d = {{2{nd2_q[0][NdW-1]}}, nd2_q[0]} + {{2{nd2_q[1][NdW-1]}}, nd2_q[1]}
           + {{2{nd2_q[2][NdW-1]}}, nd2_q[2]};
    num_abs = num3_q[NumW-1] ? (NumW'(0) - num3_q) : num3_q;
    den_abs = den3_q[DenW-1] ? (DenW'(0) - den3_q) : den3_q;
    nmag4_d = num_abs[NumMagW-1:0];
    dm4_d   = den_abs[DenMagW-1:0];
    fl4_d[1] = (den3_q == '0) || (dm4_d < {{(DenMagW-LimW){1'b0}}, limit});
    fl4_d[0] = (num3_q == '0) || (nmag4_d < {{(NumMagW-LimW){1'b0}}, limit});
    for (int i = 0; i < 3; i++) begin
      dmag4_d[i] = d3_q[i][CoordW-1] ? (CoordW'(0) - d3_q[i]) : d3_q[i];
      neg4_d[i]  = num3_q[NumW-1] ^ d3_q[i][CoordW-1] ^ den3_q[DenW-1];
      pl5_d[i]   = nmag4_q[LoW-1:0] * dmag4_q[i];
      ph5_d[i]   = nmag4_q[NumMagW-1:LoW] * dmag4_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      a_mag    = {{(AW-PlW){1'b0}}, pl5_q[i]} + {ph5_q[i], {LoW{1'b0}}};
      a6_d[i]  = {1'b0, a_mag, 1'b0} + {{(RemW-DenMagW){1'b0}}, dm5_q};
    end
    it7_d.p        = p6_q;
    it7_d.dvs      = {dm6_q, {(QuoW+1){1'b0}}};
    it7_d.neg      = neg6_q;
    it7_d.den_near = fl6_q[1];
    it7_d.num_near = fl6_q[0];
    it7_d.quo      = '0;
    for (int i = 0; i < 3; i++) begin
      it7_d.ovf[i] = a6_q[i] >= it7_d.dvs;
      it7_d.rem[i] = it7_d.ovf[i] ? '0 : a6_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
      if (r6) v6_q <= v5_q;
      if (r7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= in_data_i[i*CoordW +: CoordW];
        d1_q[i] <= in_data_i[(3+i)*CoordW +: CoordW];
        n1_q[i] <= in_data_i[(6+i)*CoordW +: CoordW];
      end
      dq1_q <= dq1_d;
    end
    if (r2 && v1_q) begin
      p2_q <= p1_q; d2_q <= d1_q; pn2_q <= pn2_d; nd2_q <= nd2_d;
    end
    if (r3 && v2_q) begin
      p3_q <= p2_q; d3_q <= d2_q; num3_q <= num3_d; den3_q <= den3_d;
    end
    if (r4 && v3_q) begin
      p4_q <= p3_q; nmag4_q <= nmag4_d; dmag4_q <= dmag4_d; dm4_q <= dm4_d;
      neg4_q <= neg4_d; fl4_q <= fl4_d;
    end
    if (r5 && v4_q) begin
      p5_q <= p4_q; pl5_q <= pl5_d; ph5_q <= ph5_d; dm5_q <= dm4_q;
      neg5_q <= neg4_q; fl5_q <= fl4_q;
    end
    if (r6 && v5_q) begin
      p6_q <= p5_q; a6_q <= a6_d; dm6_q <= dm5_q; neg6_q <= neg5_q; fl6_q <= fl5_q;
    end
    if (r7 && v6_q) it7_q <= it7_d;
  end
endmodule
`default_nettype wire

[hw/rtl/rpi_div_cell.sv]
// one restoring divider cell: one quotient bit per axis per item
// depends on rpi_pkg
`default_nettype none
module rpi_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rpi_pkg::div_item_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rpi_pkg::div_item_t out_item_o
);
  import rpi_pkg::*;

  logic      valid_q;
  div_item_t item_q, item_d;
  logic [RemW:0] shifted;
  logic [RemW:0] diff;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    item_d = in_item_i;
    for (int i = 0; i < 3; i++) begin
      shifted = {in_item_i.rem[i], 1'b0};
      diff    = shifted - {1'b0, in_item_i.dvs};
      if (shifted >= {1'b0, in_item_i.dvs}) begin
        item_d.rem[i] = diff[RemW-1:0];
        item_d.quo[i] = {in_item_i.quo[i][QuoW-2:0], 1'b1};
      end else begin
        item_d.rem[i] = shifted[RemW-1:0];
        item_d.quo[i] = {in_item_i.quo[i][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= item_d;
  end
endmodule
`default_nettype wire

[hw/rtl/rpi_back.sv]
// output stage: applies quotient sign, saturates, picks the result case
// depends on rpi_pkg
`default_nettype none
module rpi_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire rpi_pkg::div_item_t       in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [rpi_pkg::OutW-1:0]      out_data_o,
  output rpi_pkg::status_e              out_status_o
);
  import rpi_pkg::*;

  localparam logic [HitW-1:0] SatHi = HitW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic [HitW-1:0] SatLo = {{(HitW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};

  logic                   valid_q;
  logic [OutW-1:0]        data_q, data_d;
  status_e                status_q, status_d;
  logic [HitW-1:0]        p_ext, q_ext, h;
  logic [CoordW-1:0]      sat;

  assign in_ready_o   = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_data_o   = data_q;
  assign out_status_o = status_q;

  always_comb begin
    if (!in_item_i.den_near) begin
      status_d = ST_HIT;
    end else if (in_item_i.num_near) begin
      status_d = ST_IN_PLANE;
    end else begin
      status_d = ST_NONE;
    end
    for (int i = 0; i < 3; i++) begin
      p_ext = {{(HitW-CoordW){in_item_i.p[i][CoordW-1]}}, in_item_i.p[i]};
      q_ext = {2'b00, in_item_i.quo[i]};
      h     = in_item_i.neg[i] ? (p_ext + q_ext) : (p_ext - q_ext);
      if (in_item_i.ovf[i]) begin
        sat = in_item_i.neg[i] ? SatHi[CoordW-1:0] : SatLo[CoordW-1:0];
      end else if ($signed(h) > $signed(SatHi)) begin
        sat = SatHi[CoordW-1:0];
      end else if ($signed(h) < $signed(SatLo)) begin
        sat = SatLo[CoordW-1:0];
      end else begin
        sat = h[CoordW-1:0];
      end
      case (status_d)
        ST_HIT:      data_d[i*CoordW +: CoordW] = sat;
        ST_IN_PLANE: data_d[i*CoordW +: CoordW] = in_item_i.p[i];
        default:     data_d[i*CoordW +: CoordW] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q   <= data_d;
      status_q <= status_d;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/ray_plane_intersection.sv]
// ray-plane intersection top: front pipeline, chain of divider cells, output stage
// depends on rpi_pkg, rpi_front, rpi_div_cell, rpi_back and the macros header
//
// usage:
//  - input stream s_axis: twelve signed Q16.16 words per item (line point,
//    direction, plane normal, plane point), one item per cycle when ready
//  - output stream m_axis: hit x/y/z in tdata, status code in tuser
//    (hit, line in plane, parallel with no intersection; zeros for the last)
//  - cfg channel: writes the 17-bit tolerance, always ready; write only
//    while no item is in flight
//  - path: input accept to output valid runs through seven
//    front stages, 34 divider cells (one quotient bit each) and the output
//    register
//  - throughput: one item per cycle; every stage has its own valid/ready,
//    so bubbles close up and a stalled receiver fills the pipe stage by
//    stage before s_axis_tready drops
//  - reset: pipeline empties, tolerance returns to 1
`default_nettype none
`include "ray_plane_intersection_macros.svh"
module ray_plane_intersection (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // line_x, line_y, line_z, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
  // plane_x, plane_y, plane_z
  input  wire logic [rpi_pkg::InW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // hit_x, hit_y, hit_z
  output logic [rpi_pkg::OutW-1:0]        m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rpi_pkg::TolW-1:0]   cfg_data_i
);
  import rpi_pkg::*;

  logic [TolW-1:0] tol_q;
  logic            chain_valid [QuoW+1];
  logic            chain_ready [QuoW+1];
  div_item_t       chain_item  [QuoW+1];
  status_e         status;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tuser = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(1);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  rpi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_item_o  (chain_item[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    rpi_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_item_i   (chain_item[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_item_o  (chain_item[k+1])
    );
  end

  rpi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (chain_valid[QuoW]),
    .in_ready_o   (chain_ready[QuoW]),
    .in_item_i    (chain_item[QuoW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (status)
  );

  `RPI_ASSERT_IMP(a_none_zero, clk_i, rst_ni,
    m_axis_tvalid && (status == ST_NONE), m_axis_tdata == '0)
  `RPI_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `RPI_ASSERT_NXT(a_cfg_write, clk_i, rst_ni, cfg_valid_i, tol_q == $past(cfg_data_i))
endmodule
`default_nettype wire

[tb/ray_plane_intersection_test.sv]
// self-checking testbench for the ray-plane intersection block
// depends on rpi_pkg and the ray_plane_intersection rtl; streams random and
// directed items, predicts each hit point and status, checks results in order
`default_nettype none

class hit_scoreboard;
  typedef struct {
    logic [2:0][31:0]  hit;
    rpi_pkg::status_e  status;
  } hit_rec_t;

  hit_rec_t        pending[$];
  logic [16:0]     tol;
  int              errors;

  function new();
    tol = 17'd1;
    errors = 0;
  endfunction

  function automatic logic signed [191:0] mag(logic signed [191:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit near_zero(logic signed [191:0] v, logic signed [191:0] lim);
    return (v == 0) || (mag(v) < lim);
  endfunction

  function void note_input(logic [383:0] x);
    logic signed [191:0] p[3], d[3], n[3], q[3];
    logic signed [191:0] num, den, lim, prod, quo, h;
    hit_rec_t r;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(x[32*i +: 32]);
      d[i] = $signed(x[32*(3+i) +: 32]);
      n[i] = $signed(x[32*(6+i) +: 32]);
      q[i] = $signed(x[32*(9+i) +: 32]);
      num += n[i] * (p[i] - q[i]);
      den += n[i] * d[i];
    end
    lim = 0;
    lim[32:0] = {tol, 16'h0};
    if (!near_zero(den, lim)) begin
      for (int i = 0; i < 3; i++) begin
        prod = num * d[i];
        quo = (2 * mag(prod) + mag(den)) / (2 * mag(den));
        if ((prod < 0) != (den < 0)) quo = -quo;
        h = p[i] - quo;
        if (h > 192'sh7fffffff) h = 192'sh7fffffff;
        if (h < -192'sh80000000) h = -192'sh80000000;
        r.hit[i] = h[31:0];
      end
      r.status = rpi_pkg::ST_HIT;
    end else if (near_zero(num, lim)) begin
      for (int i = 0; i < 3; i++) r.hit[i] = x[32*i +: 32];
      r.status = rpi_pkg::ST_IN_PLANE;
    end else begin
      r.hit = '0;
      r.status = rpi_pkg::ST_NONE;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [95:0] data, logic [1:0] user);
    hit_rec_t r;
    bit bad;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h status %0d", data, user);
      return;
    end
    r = pending.pop_front();
    bad = 0;
    for (int i = 0; i < 3; i++)
      if (data[32*i +: 32] !== r.hit[i]) bad = 1;
    if (user !== r.status) bad = 1;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected hit %h %h %h status %0d, got %h %h %h status %0d",
                 r.hit[0], r.hit[1], r.hit[2], r.status,
                 data[31:0], data[63:32], data[95:64], user);
    end
  endfunction
endclass

module ray_plane_intersection_test;
  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [16:0]  cfg_data_i;

  hit_scoreboard sb;
  bit calm;
  bit rx_hold;

  ray_plane_intersection DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'(int'($urandom_range(0, 32)) - 16);
      default: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // kinds: 0 anything, 1 parallel, 2 line in plane, 10 and up directed
  function automatic logic [383:0] make_item(int kind);
    logic [31:0] f[12];
    logic [383:0] r;
    int a, b, c, s, e;
    for (int i = 0; i < 12; i++) f[i] = rand_field();
    a = int'($urandom_range(0, 8192)) - 4096;
    b = int'($urandom_range(0, 8192)) - 4096;
    c = int'($urandom_range(0, 8192)) - 4096;
    s = int'($urandom_range(0, 32)) - 16;
    e = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    if (kind == 1 || kind == 2) begin
      f[6] = a; f[7] = b; f[8] = 0;
      f[3] = -b; f[4] = a; f[5] = c;
    end
    if (kind == 2) begin
      f[0] = f[9] - b * s; f[1] = f[10] + a * s; f[2] = f[11] + e;
    end
    case (kind)
      10: for (int i = 0; i < 12; i++) f[i] = 32'h7fffffff;
      11: for (int i = 0; i < 12; i++) f[i] = 32'h80000000;
      12: for (int i = 0; i < 12; i++) f[i] = '0;
      13: for (int i = 0; i < 12; i++) f[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      14: for (int i = 0; i < 12; i++) f[i] = (i < 6) ? 32'h80000000 : 32'h7fffffff;
      15: begin
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[5] = 32'h10000; f[8] = 32'h10000; f[11] = 32'h50000;
      end
      16: begin
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[3] = 32'h10000; f[8] = 32'h10000; f[11] = 32'h30000;
      end
      17: begin
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[3] = 32'h7fffffff; f[4] = 32'h80000000; f[5] = 1;
        f[8] = 1; f[11] = 32'h7fffffff;
      end
      18: begin
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[3] = 3; f[5] = 1; f[8] = 2; f[11] = 1;
      end
      19: begin
        for (int i = 0; i < 12; i++) f[i] = 32'hffffffff;
        f[8] = 1;
      end
      default: ;
    endcase
    for (int i = 0; i < 12; i++) r[32*i +: 32] = f[i];
    return r;
  endfunction

  task automatic send_item(logic [383:0] x);
    int gap;
    gap = rx_hold ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(x);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [16:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.tol = v;
  endtask

  task automatic run_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      send_item(make_item(k < 5 ? 0 : (k < 7 ? 1 : 2)));
    end
  endtask

  always begin
    int gap;
    @(posedge clk_i);
    while (rst_ni) begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (rx_hold) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    calm = 0;
    rx_hold = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 10; k < 20; k++) send_item(make_item(k));
    for (int k = 0; k < 3; k++) send_item(make_item(k));
    write_tol(17'd0);
    for (int k = 10; k < 20; k++) send_item(make_item(k));

    // long receiver stall while the sender keeps offering items
    fork
      begin
        rx_hold = 1;
        repeat (200) @(posedge clk_i);
        rx_hold = 0;
      end
      run_random(120);
    join
    drain();
    run_random(190);
    write_tol(17'd65536);
    calm = 1;
    run_random(150);
    calm = 0;
    run_random(160);
    write_tol(17'($urandom_range(2, 65535)));
    run_random(310);
    write_tol(17'd1);
    run_random(150);
    calm = 1;
    run_random(160);
    calm = 0;
    write_tol(17'($urandom_range(0, 64)));
    run_random(300);
    drain();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/rpi_pkg.sv
hw/rtl/rpi_front.sv
hw/rtl/rpi_div_cell.sv
hw/rtl/rpi_back.sv
hw/rtl/ray_plane_intersection.sv
tb/ray_plane_intersection_test.sv
